FILE: hdl/fsfl_pkg.sv
// ----------------------------------------------------------------------------
// fsfl_pkg
// Shared types and constants for the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsfl_pkg;

  localparam int ADDR_W    = 32;
  localparam int SZ_W      = 16;
  localparam int CNT_W     = 9;
  localparam int OFF_W     = SZ_W + CNT_W;  // holds any offset below slot_stride * slot_limit
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_SLOTS  = 256;
  localparam int DEF_LINK_BYTES = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [ADDR_W-1:0] RST_SLAB_BASE  = 32'd4096;
  localparam logic [SZ_W-1:0]   RST_OBJ_BYTES  = 16'd8;
  localparam logic [CNT_W-1:0]  RST_SLOT_TOTAL = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLAB_BASE  = 2'd0,
    REG_OBJ_BYTES  = 2'd1,
    REG_SLOT_TOTAL = 2'd2
  } reg_index_t;

  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_NOT_OWNED = 2'd2;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] slot_address;
    logic [CNT_W-1:0]  free_count;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ACQUIRE      = 2'd0,
    OP_NULL_RELEASE = 2'd1,
    OP_BAD_RELEASE  = 2'd2,
    OP_RELEASE      = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [OFF_W-1:0] offset;
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SZ_W-1:0]   slot_stride;
    logic [CNT_W-1:0]  slot_limit;
    logic [OFF_W-1:0]  span;
  } pool_cfg_t;

endpackage

FILE: hdl/fsfl_ram.sv
// ----------------------------------------------------------------------------
// fsfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/fsfl_front.sv
// ----------------------------------------------------------------------------
// fsfl_front
// Input side: takes requests and sorts them into acquire, null release,
// out-of-range release and release that still needs the alignment check.
// ----------------------------------------------------------------------------
module fsfl_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fsfl_pkg::in_item_t   in_data,
  input  logic                 busy,
  input  fsfl_pkg::pool_cfg_t  cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output fsfl_pkg::op_t        q_op
);
  import fsfl_pkg::*;

  logic [ADDR_W-1:0] offset;

  assign offset   = in_data.address - cfg.base;
  assign in_stall = busy || q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_op.offset = offset[OFF_W-1:0];
    q_op.kind   = OP_ACQUIRE;
    case (in_data.func)
      FUNC_ACQUIRE: q_op.kind = OP_ACQUIRE;
      FUNC_RELEASE: begin
        if (in_data.address == '0) begin
          q_op.kind = OP_NULL_RELEASE;
        end else if (in_data.address < cfg.base || offset >= ADDR_W'(cfg.span)) begin
          q_op.kind = OP_BAD_RELEASE;
        end else begin
          q_op.kind = OP_RELEASE;
        end
      end
      default: q_op.kind = OP_ACQUIRE;
    endcase
  end

endmodule

FILE: hdl/fsfl_queue.sv
// ----------------------------------------------------------------------------
// fsfl_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module fsfl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fsfl_pkg::op_t push_op,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output fsfl_pkg::op_t head_op
);
  import fsfl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/fsfl_back.sv
// ----------------------------------------------------------------------------
// fsfl_back
// Execution side: owns the link memory, head, empty flag and in-use count.
// Rebuilds ascending list, pops on acquire, divides, pushes aligned release.
// ----------------------------------------------------------------------------
module fsfl_back #(
  parameter int MAX_SLOTS = fsfl_pkg::DEF_MAX_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rebuild,
  input  fsfl_pkg::pool_cfg_t cfg,
  input  logic                q_valid,
  input  fsfl_pkg::op_t       q_op,
  output logic                q_pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output fsfl_pkg::out_item_t out_data
);
  import fsfl_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int STEP_W = $clog2(CNT_W);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_ACQ  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  sweep_idx;
  logic [IDX_W-1:0]  head;
  logic              list_empty;
  logic [CNT_W-1:0]  used;
  logic [ADDR_W-1:0] product;
  logic [OFF_W-1:0]  rem;
  logic [OFF_W-1:0]  divisor;
  logic [CNT_W-1:0]  quot;
  logic [STEP_W-1:0] step;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W:0]    ram_wdata;
  logic [IDX_W:0]    ram_rdata;   // {end mark, next index}

  logic              sweep_last;
  logic              out_free;
  logic              rem_ge;
  logic              res_load;
  logic [CNT_W-1:0]  used_inc;
  logic [CNT_W-1:0]  used_dec;
  logic [IDX_W-1:0]  rel_idx;

  assign sweep_last = (32'(sweep_idx) + 32'd1) == 32'(cfg.slot_limit);
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_valid && out_free;
  assign busy       = (state == S_INIT);
  assign used_inc   = (used < cfg.slot_limit) ? used + CNT_W'(1) : used;
  assign used_dec   = (used != '0) ? used - CNT_W'(1) : used;
  assign rel_idx    = IDX_W'(quot);
  assign rem_ge     = rem >= divisor;

  // a result is loaded into the output register this cycle
  always_comb begin
    res_load = 1'b0;
    if (!rebuild) begin
      case (state)
        S_IDLE: res_load = q_pop && (q_op.kind == OP_NULL_RELEASE ||
                                     q_op.kind == OP_BAD_RELEASE ||
                                     (q_op.kind == OP_ACQUIRE && list_empty));
        S_ACQ:   res_load = 1'b1;
        S_PUSH:  res_load = 1'b1;
        default: res_load = 1'b0;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_idx;
    ram_wdata = {sweep_last, sweep_idx + IDX_W'(1)};
    if (state == S_INIT) begin
      ram_we = cfg.slot_limit != '0;
      if (sweep_last) begin
        ram_wdata = {1'b1, {IDX_W{1'b0}}};
      end
    end else if (state == S_PUSH && rem == '0) begin
      ram_we    = 1'b1;
      ram_waddr = rel_idx;
      ram_wdata = list_empty ? {1'b1, {IDX_W{1'b0}}} : {1'b0, head};
    end
  end

  fsfl_ram #(
    .WIDTH(IDX_W + 1),
    .DEPTH(MAX_SLOTS)
  ) u_link (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_idx  <= '0;
      head       <= '0;
      list_empty <= 1'b0;
      used       <= '0;
    end else begin
      if (rebuild) begin
        state     <= S_INIT;
        sweep_idx <= '0;
      end else begin
        case (state)
          S_INIT: begin
            head       <= '0;
            used       <= '0;
            list_empty <= cfg.slot_limit == '0;
            if (cfg.slot_limit == '0 || sweep_last) begin
              state <= S_IDLE;
            end else begin
              sweep_idx <= sweep_idx + IDX_W'(1);
            end
          end
          S_IDLE: begin
            if (q_pop) begin
              case (q_op.kind)
                OP_ACQUIRE: begin
                  if (list_empty) begin
                    out_data.status       <= ST_EXHAUSTED;
                    out_data.slot_address <= '0;
                    out_data.free_count   <= cfg.slot_limit - used;
                  end else begin
                    product <= ADDR_W'(head) * ADDR_W'(cfg.slot_stride);
                    state   <= S_ACQ;
                  end
                end
                OP_NULL_RELEASE: begin
                  out_data.status       <= ST_OK;
                  out_data.slot_address <= '0;
                  out_data.free_count   <= cfg.slot_limit - used;
                end
                OP_BAD_RELEASE: begin
                  out_data.status       <= ST_NOT_OWNED;
                  out_data.slot_address <= '0;
                  out_data.free_count   <= cfg.slot_limit - used;
                end
                OP_RELEASE: begin
                  rem     <= q_op.offset;
                  divisor <= OFF_W'(cfg.slot_stride) << (CNT_W - 1);
                  quot    <= '0;
                  step    <= STEP_W'(CNT_W - 1);
                  state   <= S_DIV;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
          S_ACQ: begin
            out_data.status       <= ST_OK;
            out_data.slot_address <= cfg.base + product;
            out_data.free_count   <= cfg.slot_limit - used_inc;
            used                  <= used_inc;
            if (ram_rdata[IDX_W]) begin
              list_empty <= 1'b1;
            end else begin
              head <= ram_rdata[IDX_W-1:0];
            end
            state <= S_IDLE;
          end
          S_DIV: begin
            // restoring division; quotient is known to fit CNT_W bits
            if (rem_ge) begin
              rem <= rem - divisor;
            end
            quot    <= {quot[CNT_W-2:0], rem_ge};
            divisor <= divisor >> 1;
            if (step == '0) begin
              state <= S_PUSH;
            end else begin
              step <= step - STEP_W'(1);
            end
          end
          S_PUSH: begin
            out_data.slot_address <= '0;
            if (rem == '0) begin
              head                <= rel_idx;
              list_empty          <= 1'b0;
              used                <= used_dec;
              out_data.status     <= ST_OK;
              out_data.free_count <= cfg.slot_limit - used_dec;
            end else begin
              out_data.status     <= ST_NOT_OWNED;
              out_data.free_count <= cfg.slot_limit - used;
            end
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (used <= cfg.slot_limit))
    else $error("in-use count above slot count");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (quot < cfg.slot_limit))
    else $error("release index outside pool");

  a_out_held_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACQ || state == S_DIV || state == S_PUSH) |-> !out_valid)
    else $error("output register busy during multi-cycle operation");

endmodule

FILE: hdl/fixed_slot_free_list_allocator_top.sv
// Fixed-slot pool allocator with a LIFO free list. A request passes the
// combinational front into the queue, then the back handles one request at a
// time: an acquire from a non-empty list reads the link memory and forms
// index * slot stride, then adds base; a null or out-of-range release and an
// acquire from an empty list answer straight from the idle state; an in-range
// release runs the 9-step restoring division that gives slot index and
// alignment remainder. After reset and after every register write the link
// memory is rebuilt as an ascending chain, one entry a cycle; input is stalled meanwhile.
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_top
// Configuration registers, derived slot stride and span, and the front / queue /
// back pipeline.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_top #(
  parameter int MAX_SLOTS  = fsfl_pkg::DEF_MAX_SLOTS,
  parameter int LINK_BYTES = fsfl_pkg::DEF_LINK_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fsfl_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output fsfl_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fsfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsfl_pkg::ADDR_W-1:0]          cfg_data
);
  import fsfl_pkg::*;

  logic [ADDR_W-1:0] slab_base;
  logic [SZ_W-1:0]   obj_bytes;
  logic [CNT_W-1:0]  slot_total;
  logic [OFF_W-1:0]  span;
  logic [SZ_W-1:0]   slot_stride;
  logic [CNT_W-1:0]  slot_limit;
  logic              rebuild;
  pool_cfg_t         pool_cfg;

  logic              busy;
  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  op_t               front_op;
  op_t               back_op;

  assign cfg_ready = 1'b1;
  assign rebuild   = cfg_valid && (cfg_index == REG_SLAB_BASE ||
                                   cfg_index == REG_OBJ_BYTES ||
                                   cfg_index == REG_SLOT_TOTAL);

  assign slot_limit  = (32'(slot_total) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : slot_total;
  assign slot_stride = (32'(obj_bytes) < LINK_BYTES) ? SZ_W'(LINK_BYTES) : obj_bytes;

  assign pool_cfg.base        = slab_base;
  assign pool_cfg.slot_stride = slot_stride;
  assign pool_cfg.slot_limit  = slot_limit;
  assign pool_cfg.span        = span;

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_base  <= RST_SLAB_BASE;
      obj_bytes  <= RST_OBJ_BYTES;
      slot_total <= RST_SLOT_TOTAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLAB_BASE:  slab_base  <= cfg_data;
        REG_OBJ_BYTES:  obj_bytes  <= cfg_data[SZ_W-1:0];
        REG_SLOT_TOTAL: slot_total <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // settles during the rebuild sweep, before any request is taken
  always_ff @(posedge clk) begin
    span <= OFF_W'(slot_stride) * OFF_W'(slot_limit);
  end

  fsfl_front u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .busy    (busy),
    .cfg     (pool_cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (front_op)
  );

  fsfl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .push_op(front_op),
    .full   (q_full),
    .valid  (q_valid),
    .pop    (q_pop),
    .head_op(back_op)
  );

  fsfl_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rebuild  (rebuild),
    .cfg      (pool_cfg),
    .q_valid  (q_valid),
    .q_op     (back_op),
    .q_pop    (q_pop),
    .busy     (busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
